// ===== rtl/core/bscp_pkg.sv =====
// Package for the bit-selected matrix chain product block.
// Holds the beat structs, command/status structs, widths and codes; no dependencies.
package bscp_pkg;

  // Largest matrix dimension supported by default
  localparam int MAX_DIM_DEF = 8;

  // Fixed field widths of the channels
  localparam int IDX_PORT_W = 3;
  localparam int SIZE_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int PROD_W     = 64;
  localparam int HALF_W     = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // Operation codes of an input beat
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // Input beat
  typedef struct packed {
    logic                  op;
    logic                  matrix_select;
    logic [IDX_PORT_W-1:0] load_row;
    logic [IDX_PORT_W-1:0] load_col;
    logic [VALUE_W-1:0]    element_value;
    logic                  selector_bit;
    logic                  first_bit;
    logic                  last_bit;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [IDX_PORT_W-1:0] out_row;
    logic [IDX_PORT_W-1:0] out_col;
    logic [PROD_W-1:0]     product_value;
    logic                  last_element;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                  key_we;
    logic                  key_sel;
    logic [VALUE_W-1:0]    value;
    logic [IDX_PORT_W-1:0] row;
    logic [IDX_PORT_W-1:0] col;
    logic [IDX_PORT_W-1:0] kidx;
    logic                  mac;
    logic                  mac_sel;
    logic                  k_first;
    logic                  k_last;
    logic                  clear_valid;
    logic                  copy_rd;
    logic                  emit_rd;
    logic                  last_elem;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/bit_selected_matrix_chain_product.sv =====
// Bit-selected matrix chain product: holds two square key matrices of 32-bit elements and
// folds selector bits into a 64-bit running product, P := K[bit] * P, wrapping modulo 2^64.
// A load beat writes one key element. An apply beat with effective size n (the configured
// size clamped to 1..MAX_DIM) runs n*n*n steps through the single multiply-accumulate
// pipeline, waits for the pipeline and output register to drain, then sweeps n*n cells copying
// the scratch result into the running product; with last_bit set it then emits n*n beats in
// row-major order, one per cycle while out_stall is low. The block takes a new beat only when
// the previous one has finished; there is no clearing pass after reset. Built from bscp_ctrl
// and bscp_datapath, types in bscp_pkg.
module bit_selected_matrix_chain_product #(
  parameter int MAX_DIM = bscp_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bscp_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bscp_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bscp_pkg::SIZE_W-1:0]  cfg_data
);
  import bscp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  bscp_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Memories and arithmetic
  bscp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/bscp_ctrl.sv =====
// Controller of the bit-selected matrix chain product block.
// Sequences load, multiply-accumulate, drain, copy and emit phases; uses bscp_pkg.
module bscp_ctrl #(
  parameter int MAX_DIM = bscp_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bscp_pkg::in_item_t              in_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bscp_pkg::SIZE_W-1:0]     cfg_data,
  input  bscp_pkg::stat_t                 stat,
  output bscp_pkg::cmd_t                  cmd
);
  import bscp_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  size_r;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               sel_r, sel_nxt;
  logic               last_r, last_nxt;
  logic [IDX_W-1:0]   nm1;
  logic               accept;
  logic               load_in_range;

  // Clamp the configured size and keep the last index in use
  always_comb begin
    priority if (size_r == '0) begin
      nm1 = '0;
    end else if (32'(size_r) > MAX_DIM) begin
      nm1 = IDX_W'(MAX_DIM - 1);
    end else begin
      nm1 = IDX_W'(size_r - SIZE_W'(1));
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_in_range = (32'(in_data.load_row) < MAX_DIM) &&
                         (32'(in_data.load_col) < MAX_DIM);

  // Next state and loop counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.op == OP_APPLY)) begin
          state_nxt = ST_MAC;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          sel_nxt   = in_data.selector_bit;
          last_nxt  = in_data.last_bit;
        end
      end
      ST_MAC: begin
        if (k_r == nm1) begin
          k_nxt = '0;
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) begin
              i_nxt     = '0;
              state_nxt = ST_DRAIN;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && !stat.out_busy) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (j_r == nm1) begin
          j_nxt = '0;
          if (i_r == nm1) begin
            i_nxt     = '0;
            state_nxt = last_r ? ST_EMIT : ST_IDLE;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) begin
              i_nxt     = '0;
              state_nxt = ST_IDLE;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    cmd             = '0;
    cmd.key_we      = accept && (in_data.op == OP_LOAD) && load_in_range;
    cmd.key_sel     = in_data.matrix_select;
    cmd.value       = in_data.element_value;
    cmd.clear_valid = accept && (in_data.op == OP_APPLY) && in_data.first_bit;
    cmd.mac_sel     = sel_r;
    cmd.kidx        = IDX_PORT_W'(k_r);
    cmd.k_first     = (k_r == '0);
    cmd.k_last      = (k_r == nm1);
    cmd.last_elem   = (i_r == nm1) && (j_r == nm1);
    cmd.mac         = (state_r == ST_MAC);
    cmd.copy_rd     = (state_r == ST_COPY);
    cmd.emit_rd     = (state_r == ST_EMIT) && stat.out_free;
    if (state_r == ST_IDLE) begin
      cmd.row = in_data.load_row;
      cmd.col = in_data.load_col;
    end else begin
      cmd.row = IDX_PORT_W'(i_r);
      cmd.col = IDX_PORT_W'(j_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= SIZE_RESET;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
    end
  end

  // Item flags, held for the whole item
  always_ff @(posedge clk) begin
    sel_r  <= sel_nxt;
    last_r <= last_nxt;
  end

  // An accepted apply beat always starts the multiply phase
  a_apply_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == OP_APPLY)) |=> (state_r == ST_MAC))
    else $error("apply beat did not start the multiply phase");

  // Issuing the final element ends the item
  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rd && cmd.last_elem) |=> (state_r == ST_IDLE))
    else $error("final element issued but controller not idle");

endmodule

// ===== rtl/core/bscp_datapath.sv =====
// Datapath of the bit-selected matrix chain product block.
// Key, product and scratch memories, multiply-accumulate pipeline, output register; uses bscp_pkg.
module bscp_datapath #(
  parameter int MAX_DIM = bscp_pkg::MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bscp_pkg::cmd_t       cmd,
  output bscp_pkg::stat_t      stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bscp_pkg::out_item_t  out_data
);
  import bscp_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  function automatic logic [CELL_W-1:0] cell_addr(input logic [IDX_PORT_W-1:0] r,
                                                  input logic [IDX_PORT_W-1:0] c);
    return CELL_W'(CELL_W'(r[IDX_W-1:0]) * CELL_W'(MAX_DIM)) + CELL_W'(c[IDX_W-1:0]);
  endfunction

  logic [VALUE_W-1:0] key0_mem [CELLS];
  logic [VALUE_W-1:0] key1_mem [CELLS];
  logic [PROD_W-1:0]  prod_mem [CELLS];
  logic [PROD_W-1:0]  scr_mem  [CELLS];
  logic [CELLS-1:0]   valid_r;

  logic [CELL_W-1:0]  rc_addr, key_rd_addr, prod_rd_addr;

  // Stage 1: operands read from memory
  logic               s1_vld_r, s1_first_r, s1_last_r, s1_sel_r;
  logic [CELL_W-1:0]  s1_dst_r;
  logic [VALUE_W-1:0] key0_rd_r, key1_rd_r;
  logic [PROD_W-1:0]  prod_rd_r;
  logic               pv_r, diag_r;
  logic [VALUE_W-1:0] key_op;
  logic [PROD_W-1:0]  prod_op;
  logic [PROD_W-1:0]  mul_lo_nxt;
  logic [HALF_W-1:0]  mul_hi_nxt;

  // Stage 2: partial products
  logic               s2_vld_r, s2_first_r, s2_last_r;
  logic [CELL_W-1:0]  s2_dst_r;
  logic [PROD_W-1:0]  mul_lo_r;
  logic [HALF_W-1:0]  mul_hi_r;

  // Stage 3: summed term and accumulator
  logic               s3_vld_r, s3_first_r, s3_last_r;
  logic [CELL_W-1:0]  s3_dst_r;
  logic [PROD_W-1:0]  term_r;
  logic [PROD_W-1:0]  acc_r, acc_nxt;

  // Copy and output
  logic               cp_we_r;
  logic [CELL_W-1:0]  cp_addr_r;
  logic [PROD_W-1:0]  scr_rd_r;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_PORT_W-1:0] out_row_r, out_col_r;
  logic               out_last_r;

  assign rc_addr      = cell_addr(cmd.row, cmd.col);
  assign key_rd_addr  = cell_addr(cmd.row, cmd.kidx);
  assign prod_rd_addr = cell_addr(cmd.kidx, cmd.col);

  // Key matrix 0: element loads, reads for the multiply
  always_ff @(posedge clk) begin
    if (cmd.key_we && !cmd.key_sel) begin
      key0_mem[rc_addr] <= cmd.value;
    end
    if (cmd.mac) begin
      key0_rd_r <= key0_mem[key_rd_addr];
    end
  end

  // Key matrix 1
  always_ff @(posedge clk) begin
    if (cmd.key_we && cmd.key_sel) begin
      key1_mem[rc_addr] <= cmd.value;
    end
    if (cmd.mac) begin
      key1_rd_r <= key1_mem[key_rd_addr];
    end
  end

  // Running product: written by the copy sweep, read by the multiply
  always_ff @(posedge clk) begin
    if (cp_we_r) begin
      prod_mem[cp_addr_r] <= scr_rd_r;
    end
    if (cmd.mac) begin
      prod_rd_r <= prod_mem[prod_rd_addr];
    end
  end

  // Scratch: written at the end of each dot product, read by copy and emit
  always_ff @(posedge clk) begin
    if (s3_vld_r && s3_last_r) begin
      scr_mem[s3_dst_r] <= acc_nxt;
    end
    if (cmd.copy_rd || cmd.emit_rd) begin
      scr_rd_r <= scr_mem[rc_addr];
    end
  end

  // Invalid product entries read as the identity
  assign key_op  = s1_sel_r ? key1_rd_r : key0_rd_r;
  assign prod_op = pv_r ? prod_rd_r : (diag_r ? PROD_W'(1) : '0);

  // Split the 32x64 multiply into two 32x32 halves; the upper half wraps
  assign mul_lo_nxt = PROD_W'(key_op) * PROD_W'(prod_op[HALF_W-1:0]);
  assign mul_hi_nxt = key_op * prod_op[PROD_W-1:HALF_W];

  assign acc_nxt = s3_first_r ? term_r : acc_r + term_r;

  always_comb begin
    if (cmd.emit_rd) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Pipeline control, valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      cp_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      s1_vld_r    <= cmd.mac;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      cp_we_r     <= cmd.copy_rd;
      out_valid_r <= out_valid_nxt;
      // A fresh chain wins over a pending copy write
      if (cmd.clear_valid) begin
        valid_r <= '0;
      end else if (cp_we_r) begin
        valid_r[cp_addr_r] <= 1'b1;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_first_r <= cmd.k_first;
    s1_last_r  <= cmd.k_last;
    s1_sel_r   <= cmd.mac_sel;
    s1_dst_r   <= rc_addr;
    pv_r       <= valid_r[prod_rd_addr];
    diag_r     <= (cmd.kidx == cmd.col);

    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_dst_r   <= s1_dst_r;
    mul_lo_r   <= mul_lo_nxt;
    mul_hi_r   <= mul_hi_nxt;

    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    s3_dst_r   <= s2_dst_r;
    term_r     <= mul_lo_r + {mul_hi_r, {HALF_W{1'b0}}};

    if (s3_vld_r) begin
      acc_r <= acc_nxt;
    end

    cp_addr_r <= rc_addr;

    if (cmd.emit_rd) begin
      out_row_r  <= cmd.row;
      out_col_r  <= cmd.col;
      out_last_r <= cmd.last_elem;
    end
  end

  assign stat.pipe_busy = s1_vld_r || s2_vld_r || s3_vld_r;
  assign stat.out_busy  = out_valid_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid              = out_valid_r;
  assign out_data.out_row       = out_row_r;
  assign out_data.out_col       = out_col_r;
  assign out_data.product_value = scr_rd_r;
  assign out_data.last_element  = out_last_r;

  // The copy sweep reuses the output data register, so it needs a drained block
  a_copy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_rd |-> (!s1_vld_r && !s2_vld_r && !s3_vld_r && !out_valid_r))
    else $error("copy sweep started with work in flight");

  // An emit read never overwrites a beat that is still stalled
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rd |-> (!out_valid_r || !out_stall))
    else $error("emit read overwrote a stalled beat");

endmodule
